// ----- design/fct_pkg.sv -----
package fct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 12;
    localparam int PTR_W       = ENTRY_W + 1;

    // entry codes
    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 12'h000;
    localparam logic [ENTRY_W-1:0] ENTRY_BAD  = 12'hFF7;
    localparam logic [ENTRY_W-1:0] ENTRY_EOC  = 12'hFF8;
    localparam logic [PTR_W-1:0]   FIRST_DATA = PTR_W'(2);
    localparam logic [PTR_W-1:0]   DEPTH_P    = PTR_W'(TABLE_DEPTH);
    localparam logic [PTR_W-1:0]   LAST_P     = PTR_W'(TABLE_DEPTH - 1);

    // operation codes
    localparam logic [1:0] MODE_GET   = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_ALLOC = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [ENTRY_W-1:0] TOTAL_RESET = 12'd4085;
    localparam logic REG_TOTAL = 1'b0;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ENTRY_W-1:0] cluster;
        logic [ENTRY_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [ENTRY_W-1:0] result_value;
        logic               table_full;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GET_RD,
        S_GET_DONE,
        S_SET,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_WALK_CHK,
        S_WALK_WAIT
    } t_state;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_LOAD_CL,
        PTR_FIRST,
        PTR_INC,
        PTR_LINK
    } t_ptr_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ZERO,
        WR_VALUE,
        WR_EOC
    } t_wr_op;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_READ,
        RES_PTR,
        RES_FULL
    } t_res_sel;

    typedef struct packed {
        logic     cap;
        t_ptr_op  ptr_op;
        logic     rd;
        t_wr_op   wr_op;
        logic     done;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic ptr_in_mem;
        logic clr_last;
        logic scan_ok;
        logic rdata_free;
        logic rdata_eoc;
        logic walk_ok;
    } t_dp_status;

endpackage

// ----- design/fct_ctrl.sv -----
module fct_ctrl
    import fct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_mode)
                        MODE_GET:   n_state = S_GET_RD;
                        MODE_SET:   n_state = S_SET;
                        MODE_ALLOC: n_state = S_SCAN_RD;
                        MODE_FREE:  n_state = S_WALK_CHK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_GET_RD:   n_state = S_GET_DONE;
            S_GET_DONE: n_state = S_IDLE;
            S_SET:      n_state = S_IDLE;
            S_SCAN_RD: begin
                n_state = i_status.scan_ok ? S_SCAN_CHK : S_IDLE;
            end
            S_SCAN_CHK: begin
                n_state = i_status.rdata_free ? S_IDLE : S_SCAN_RD;
            end
            S_WALK_CHK: begin
                n_state = i_status.walk_ok ? S_WALK_WAIT : S_IDLE;
            end
            S_WALK_WAIT: begin
                n_state = i_status.rdata_eoc ? S_IDLE : S_WALK_CHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.ptr_op  = PTR_HOLD;
        o_cmd.wr_op   = WR_NONE;
        o_cmd.res_sel = RES_ZERO;
        o_busy        = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_op  = WR_ZERO;
                o_cmd.ptr_op = PTR_INC;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap    = 1'b1;
                    o_cmd.ptr_op = (i_mode == MODE_ALLOC) ? PTR_FIRST : PTR_LOAD_CL;
                end
            end
            S_GET_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_GET_DONE: begin
                o_cmd.done    = 1'b1;
                o_cmd.res_sel = i_status.ptr_in_mem ? RES_READ : RES_ZERO;
            end
            S_SET: begin
                o_cmd.wr_op = i_status.ptr_in_mem ? WR_VALUE : WR_NONE;
                o_cmd.done  = 1'b1;
            end
            S_SCAN_RD: begin
                if (i_status.scan_ok) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_cmd.done    = 1'b1;
                    o_cmd.res_sel = RES_FULL;
                end
            end
            S_SCAN_CHK: begin
                if (i_status.rdata_free) begin
                    o_cmd.wr_op   = WR_EOC;
                    o_cmd.done    = 1'b1;
                    o_cmd.res_sel = RES_PTR;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_WALK_CHK: begin
                if (i_status.walk_ok) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_cmd.done = 1'b1;
                end
            end
            S_WALK_WAIT: begin
                o_cmd.wr_op = WR_ZERO;
                if (i_status.rdata_eoc) begin
                    o_cmd.done = 1'b1;
                end else begin
                    o_cmd.ptr_op = PTR_LINK;
                end
            end
            default: begin
                o_cmd.done = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/fct_dpath.sv -----
module fct_dpath
    import fct_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  t_cmd               i_req,
    input  logic [ENTRY_W-1:0] i_total_clusters,
    output t_dp_status         o_status,
    output logic               o_done,
    output t_result            o_result
);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   n_ptr;
    logic [PTR_W-1:0]   r_steps;
    logic [PTR_W-1:0]   n_steps;
    logic [ENTRY_W-1:0] r_value;
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_done;
    t_result            r_result;
    t_result            n_result;

    logic [ADDR_W-1:0]  addr;
    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic [PTR_W-1:0]   total_p1;
    logic [PTR_W-1:0]   scan_last;

    assign addr = r_ptr[ADDR_W-1:0];

    // write port
    always_comb begin
        we    = 1'b1;
        wdata = ENTRY_FREE;
        case (i_cmd.wr_op)
            WR_ZERO:  wdata = ENTRY_FREE;
            WR_VALUE: wdata = r_value;
            WR_EOC:   wdata = ENTRY_EOC;
            default:  we    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
        end
    end

    // pointer and walk guard
    always_comb begin
        n_ptr   = r_ptr;
        n_steps = r_steps;
        case (i_cmd.ptr_op)
            PTR_ZERO:    n_ptr = '0;
            PTR_LOAD_CL: n_ptr = {1'b0, i_req.cluster};
            PTR_FIRST:   n_ptr = FIRST_DATA;
            PTR_INC:     n_ptr = r_ptr + PTR_W'(1);
            PTR_LINK: begin
                n_ptr   = {1'b0, r_rdata};
                n_steps = r_steps + PTR_W'(1);
            end
            default:     n_ptr = r_ptr;
        endcase
        if (i_cmd.cap) begin
            n_steps = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_steps <= '0;
        end else begin
            r_ptr   <= n_ptr;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_value <= i_req.value;
        end
    end

    // scan bound: lower of total + 1 and the last entry
    assign total_p1  = {1'b0, i_total_clusters} + PTR_W'(1);
    assign scan_last = (total_p1 > LAST_P) ? LAST_P : total_p1;

    always_comb begin
        o_status.ptr_in_mem = (r_ptr < DEPTH_P);
        o_status.clr_last   = (r_ptr == LAST_P);
        o_status.scan_ok    = (i_total_clusters != '0) && (r_ptr <= scan_last);
        o_status.rdata_free = (r_rdata == ENTRY_FREE);
        o_status.rdata_eoc  = (r_rdata >= ENTRY_EOC);
        o_status.walk_ok    = (r_ptr >= FIRST_DATA) && (r_ptr < {1'b0, ENTRY_BAD})
                              && (r_ptr < DEPTH_P) && (r_steps < DEPTH_P);
    end

    // result register
    always_comb begin
        n_result = '0;
        case (i_cmd.res_sel)
            RES_READ: n_result.result_value = r_rdata;
            RES_PTR:  n_result.result_value = r_ptr[ENTRY_W-1:0];
            RES_FULL: n_result.table_full   = 1'b1;
            default:  n_result              = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- design/fat12_cluster_table_engine.sv -----
// get reads the entry and reports it; set writes the entry; allocate reads and checks the
// entries in turn from cluster 2 until one is free, which it marks with an end marker, or the bound is passed;
// free chain clears each entry and follows its link until an end marker stops it or a check fails
// one request at a time; the single-port table memory, read then checked, sets the pace
// reset: a clearing pass writes all 4096 entries to zero, with busy high throughout
// results appear on o_result with o_done, high for one cycle, and hold until the next; the receiver cannot stall
module fat12_cluster_table_engine
    import fct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    // result channel
    output logic                  o_done,
    output t_result               o_result,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [ENTRY_W-1:0] r_total_clusters;
    logic               cfg_wr;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    // configuration register: total cluster count, word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_clusters <= TOTAL_RESET;
        end else if (cfg_wr) begin
            r_total_clusters <= pwdata[ENTRY_W-1:0];
        end
    end

    // reads beyond the register list return zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TOTAL) begin
            prdata = CFG_DATA_W'(r_total_clusters);
        end
    end

    // sequencer: clearing pass, then one request at a time
    fct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_cmd.mode),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // table memory, walk pointer and result register
    fct_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_req            (i_cmd),
        .i_total_clusters (r_total_clusters),
        .o_status         (dp_status),
        .o_done           (o_done),
        .o_result         (o_result)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top
    import fct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // byte address of the one configuration register
    localparam logic [CFG_ADDR_W-1:0] TOTAL_ADDR = CFG_ADDR_W'(4 * int'(REG_TOTAL));
    localparam int N_PHASES   = 6;
    localparam int PHASE_REQS = 125;
    localparam int DRAIN_WAIT = 50;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd   = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    fat12_cluster_table_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // mirror of the allocation table and of the cluster count register
    logic [ENTRY_W-1:0] fat_model [TABLE_DEPTH];
    logic [ENTRY_W-1:0] model_total = TOTAL_RESET;

    t_cmd    req_backlog [$];   // requests still to be offered
    t_result want_results [$];  // predicted results, oldest first
    int      idle_pct  = 0;     // chance in a hundred that the sender holds back
    int      err_count = 0;
    int      reqs_queued = 0;

    int          phase_idle  [N_PHASES] = '{70, 21, 0, 70, 21, 70};
    logic [11:0] phase_total [N_PHASES];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // apply one request to the mirror table and work out its result
    function automatic t_result fat_apply(t_cmd c);
        t_result            r;
        logic [PTR_W-1:0]   last;
        logic [PTR_W-1:0]   p;
        logic [ENTRY_W-1:0] nxt;
        int                 steps;
        r = '0;
        case (c.mode)
            MODE_GET: begin
                r.result_value = fat_model[c.cluster];
            end
            MODE_SET: begin
                fat_model[c.cluster] = c.value;
            end
            MODE_ALLOC: begin
                // scan 2 .. total+1, capped at the last entry; a zero count scans nothing
                r.table_full = 1'b1;
                last = {1'b0, model_total} + PTR_W'(1);
                if (last > LAST_P) last = LAST_P;
                if (model_total != '0) begin
                    for (p = FIRST_DATA; p <= last; p++) begin
                        if (fat_model[p[ENTRY_W-1:0]] == ENTRY_FREE) begin
                            fat_model[p[ENTRY_W-1:0]] = ENTRY_EOC;
                            r.result_value = p[ENTRY_W-1:0];
                            r.table_full   = 1'b0;
                            break;
                        end
                    end
                end
            end
            default: begin
                // free chain: visit only clusters 2 .. 0xFF6, stop after an end marker
                p = {1'b0, c.cluster};
                steps = 0;
                while (p >= FIRST_DATA && p < {1'b0, ENTRY_BAD} && p < DEPTH_P &&
                       steps < TABLE_DEPTH) begin
                    nxt = fat_model[p[ENTRY_W-1:0]];
                    fat_model[p[ENTRY_W-1:0]] = ENTRY_FREE;
                    if (nxt >= ENTRY_EOC) break;
                    p = {1'b0, nxt};
                    steps++;
                end
            end
        endcase
        return r;
    endfunction

    // request driver: offers the backlog, holds a request until it is taken
    always @(posedge i_clk) begin : req_driver
        logic taken;
        taken = start && !busy;
        if (taken) want_results.push_back(fat_apply(i_cmd));
        if (!start || taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_cmd <= req_backlog.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor: each strobed result against the oldest prediction
    always @(posedge i_clk) begin : res_monitor
        t_result w;
        if (i_rst_n && o_done === 1'b1) begin
            if (want_results.size() == 0) begin
                report_mismatch("result with no request pending", int'(o_result), 0);
            end else begin
                w = want_results.pop_front();
                if (o_result.result_value !== w.result_value)
                    report_mismatch("result_value", o_result.result_value, w.result_value);
                if (o_result.table_full !== w.table_full)
                    report_mismatch("table_full", o_result.table_full, w.table_full);
            end
        end
    end

    task automatic push_req(logic [1:0] m, logic [11:0] cl, logic [11:0] v);
        t_cmd c;
        c.mode    = m;
        c.cluster = cl;
        c.value   = v;
        req_backlog.push_back(c);
        reqs_queued++;
    endtask

    // apb write of the cluster count, then a read back of it
    task automatic cfg_total(logic [11:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_ADDR;
        pwdata  <= CFG_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        model_total = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[ENTRY_W-1:0] !== v)
            report_mismatch("total_clusters read back", prdata[ENTRY_W-1:0], v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // block idle: backlog offered, every result in, no walk under way
    task automatic wait_drained();
        @(posedge i_clk);
        while (req_backlog.size() != 0 || start || want_results.size() != 0 ||
               busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // mostly a small window so chains, allocations and gets collide
    function automatic logic [11:0] pick_cluster();
        if ($urandom_range(99) < 80) return 12'($urandom_range(63, 2));
        return 12'($urandom_range(12'hFF6, 2));
    endfunction

    // link a few distinct clusters, look at them, free from the head, look again
    task automatic gen_chain(bit broken);
        logic [11:0] links [6];
        logic [11:0] cand;
        logic [11:0] tail;
        int          k;
        bit          dup;
        k = $urandom_range(6, 1);
        for (int j = 0; j < k; j++) begin
            do begin
                cand = pick_cluster();
                dup  = 1'b0;
                for (int m = 0; m < j; m++) if (links[m] == cand) dup = 1'b1;
            end while (dup);
            links[j] = cand;
        end
        for (int j = 0; j < k - 1; j++) push_req(MODE_SET, links[j], links[j+1]);
        if (!broken) begin
            tail = 12'($urandom_range(12'hFFF, ENTRY_EOC));
        end else begin
            // free marker, reserved entry, bad cluster, loop back, or anything
            case ($urandom_range(4))
                0:       tail = ENTRY_FREE;
                1:       tail = 12'd1;
                2:       tail = ENTRY_BAD;
                3:       tail = links[0];
                default: tail = 12'($urandom);
            endcase
        end
        push_req(MODE_SET, links[k-1], tail);
        if ($urandom_range(1)) push_req(MODE_GET, links[$urandom_range(k - 1)], 12'($urandom));
        if ($urandom_range(3) == 0) push_req(MODE_ALLOC, 12'($urandom), 12'($urandom));
        push_req(MODE_FREE, links[0], 12'($urandom));
        push_req(MODE_GET, links[$urandom_range(k - 1)], 12'($urandom));
        push_req(MODE_GET, links[k-1], 12'($urandom));
    endtask

    task automatic gen_phase(int n);
        int first;
        int r;
        first = reqs_queued;
        while (reqs_queued - first < n) begin
            r = $urandom_range(99);
            if (r < 50) begin
                gen_chain(1'b0);
            end else if (r < 65) begin
                gen_chain(1'b1);
            end else if (r < 80) begin
                repeat ($urandom_range(4, 1)) push_req(MODE_ALLOC, 12'($urandom), 12'($urandom));
                push_req(MODE_GET, 12'($urandom_range(63, 0)), 12'($urandom));
            end else begin
                push_req(2'($urandom_range(3)), 12'($urandom), 12'($urandom));
            end
        end
    endtask

    initial begin
        foreach (fat_model[i]) fat_model[i] = ENTRY_FREE;
        phase_total[0] = 12'd1;
        phase_total[1] = 12'd0;
        phase_total[2] = 12'hFFF;
        phase_total[3] = 12'($urandom_range(48, 2));
        phase_total[4] = TOTAL_RESET;
        phase_total[5] = 12'($urandom_range(4095, 1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass after reset keeps busy high
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        // directed requests under the reset cluster count, sender never idle
        push_req(MODE_GET,   12'd0,    12'hFFF);   // cleared table reads zero
        push_req(MODE_SET,   12'hFFF,  12'hFFF);   // top entry, all ones
        push_req(MODE_GET,   12'hFFF,  12'h000);
        push_req(MODE_SET,   12'd0,    12'hABC);   // reserved entries reachable by get/set
        push_req(MODE_GET,   12'd0,    12'h000);
        push_req(MODE_SET,   12'd1,    12'h543);
        push_req(MODE_ALLOC, 12'd0,    12'h000);   // first data cluster
        push_req(MODE_ALLOC, 12'hFFF,  12'hFFF);
        push_req(MODE_SET,   12'd4,    12'd5);     // two-link chain ending in end marker
        push_req(MODE_SET,   12'd5,    ENTRY_EOC);
        push_req(MODE_FREE,  12'd4,    12'h000);
        push_req(MODE_GET,   12'd5,    12'h000);
        push_req(MODE_SET,   12'd6,    12'd7);     // looping chain
        push_req(MODE_SET,   12'd7,    12'd6);
        push_req(MODE_FREE,  12'd6,    12'h000);
        push_req(MODE_GET,   12'd7,    12'h000);
        push_req(MODE_SET,   12'hFF7,  12'd3);     // bad cluster as link and as start
        push_req(MODE_SET,   12'd8,    ENTRY_BAD);
        push_req(MODE_FREE,  12'd8,    12'h000);
        push_req(MODE_FREE,  12'hFF7,  12'h000);
        push_req(MODE_GET,   12'hFF7,  12'h000);
        push_req(MODE_SET,   12'hFF6,  12'hFFF);   // highest valid start
        push_req(MODE_FREE,  12'hFF6,  12'h000);
        push_req(MODE_FREE,  12'd1,    12'h000);   // reserved start, nothing freed
        push_req(MODE_FREE,  12'hFFF,  12'h000);   // start beyond the data range
        push_req(MODE_GET,   12'd1,    12'h000);
        push_req(MODE_GET,   12'hFFF,  12'h000);
        wait_drained();

        // random phases, each under its own cluster count and sender idle rate
        for (int p = 0; p < N_PHASES; p++) begin
            cfg_total(phase_total[p]);
            idle_pct = phase_idle[p];
            gen_phase(PHASE_REQS);
            wait_drained();
        end

        // quiet tail to catch any stray result
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog: far beyond a run in which every request walks the whole table
    initial begin
        #500_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
